// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int LEVELS      = 10;

  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ENTRY_W     = 64;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] task_handle;
    logic [31:0] argument_handle;
    logic [3:0]  priority_req;
  } spq_cmd_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] task_out;
    logic [31:0] argument_out;
    logic        push_dropped;
  } spq_result_t;

  // store access decided for the accepted word
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              dropped;
  } spq_access_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [PTR_W-1:0] p);
    return ADDR_W'(int'(lvl) * QUEUE_DEPTH + int'(p));
  endfunction

endpackage

// ===== hdl/strict_priority_task_queues_unit.sv =====
// Strict-priority task queues: LEVELS rings of QUEUE_DEPTH entries each, all held
// in one single-port-write, registered-read entry RAM. A word is accepted on any
// clock edge where start is high and busy is low; busy stays low, so one push or
// pop word can be issued every cycle. Each accepted word returns exactly one
// result in the cycle after acceptance, flagged by done for a single cycle; the receiver
// cannot stall it and must take it then. The RAM read registers the result: the
// level pick (priority encoder over the per-level counts) and the RAM address are
// formed in the cycle of acceptance. A push to a full level, or with a priority
// outside 1..LEVELS, is refused with push_dropped set. A pop with every level
// empty returns entry_valid low and zero data. No clearing pass after reset.
module strict_priority_task_queues_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  spq_pkg::spq_cmd_t     cmd,
  output logic                  done,
  output spq_pkg::spq_result_t  result
);
  import spq_pkg::*;

  logic              accept;
  spq_access_t       access;
  logic [ENTRY_W-1:0] rdata;
  logic              hit;
  logic              dropped;

  // the store is never locked: one word per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // pointers, counts and level selection
  spq_level_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .access (access)
  );

  // entry RAM: task in the upper word, argument in the lower word
  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (access.we),
    .waddr (access.waddr),
    .wdata ({cmd.task_handle, cmd.argument_handle}),
    .re    (access.re),
    .raddr (access.raddr),
    .rdata (rdata)
  );

  // result flags line up with the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      hit     <= 1'b0;
      dropped <= 1'b0;
    end else begin
      done    <= accept;
      hit     <= access.re;
      dropped <= access.dropped;
    end
  end

  // data is zero unless a pop found an entry
  always_comb begin
    result.entry_valid  = hit;
    result.task_out     = hit ? rdata[ENTRY_W-1:32] : 32'd0;
    result.argument_out = hit ? rdata[31:0] : 32'd0;
    result.push_dropped = dropped;
  end

`ifndef SYNTHESIS
  // every result answers a word taken on the edge before
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without an accepted word");

  // a pop never reports a dropped push
  a_pop_no_drop: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.mode == MODE_POP) |=> (done && !result.push_dropped))
    else $error("pop result flagged as dropped push");

  // a push never returns an entry
  a_push_no_entry: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.mode == MODE_PUSH) |=> (done && !result.entry_valid))
    else $error("push result carries an entry");
`endif

endmodule

// ===== hdl/spq_ram.sv =====
module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/spq_level_ctrl.sv =====
module spq_level_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  spq_pkg::spq_cmd_t   cmd,
  output spq_pkg::spq_access_t access
);
  import spq_pkg::*;

  logic [PTR_W-1:0] rd_ptr [LEVELS];
  logic [PTR_W-1:0] wr_ptr [LEVELS];
  logic [CNT_W-1:0] count  [LEVELS];

  logic             pop_hit;
  logic [LVL_W-1:0] pop_lvl;
  logic [LVL_W-1:0] push_lvl;
  logic             prio_ok;
  logic             push_ok;
  logic             is_push;
  logic             is_pop;

  // lowest-numbered non-empty level wins
  always_comb begin
    pop_hit = 1'b0;
    pop_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        pop_hit = 1'b1;
        pop_lvl = LVL_W'(i);
      end
    end
  end

  assign push_lvl = LVL_W'(cmd.priority_req - 4'd1);
  assign prio_ok  = (cmd.priority_req != 4'd0) && (int'(cmd.priority_req) <= LEVELS);
  assign push_ok  = prio_ok && (count[push_lvl] != CNT_W'(QUEUE_DEPTH));
  assign is_push  = accept && (cmd.mode == MODE_PUSH);
  assign is_pop   = accept && (cmd.mode == MODE_POP);

  always_comb begin
    access.we      = is_push && push_ok;
    access.waddr   = store_addr(push_lvl, prio_ok ? wr_ptr[push_lvl] : '0);
    access.re      = is_pop && pop_hit;
    access.raddr   = store_addr(pop_lvl, rd_ptr[pop_lvl]);
    access.dropped = is_push && !push_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        count[i]  <= '0;
      end
    end else begin
      if (access.we) begin
        wr_ptr[push_lvl] <= ptr_next(wr_ptr[push_lvl]);
        count[push_lvl]  <= count[push_lvl] + CNT_W'(1);
      end
      if (access.re) begin
        rd_ptr[pop_lvl] <= ptr_next(rd_ptr[pop_lvl]);
        count[pop_lvl]  <= count[pop_lvl] - CNT_W'(1);
      end
    end
  end

endmodule

// ===== dv/spq_checker.sv =====
`timescale 1ns / 100ps

// Watches the command and result channels of the priority task queues,
// keeps its own copy of the ten rings and checks every result word in order.
module spq_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  spq_pkg::spq_cmd_t    cmd,
  input  logic                 done,
  input  spq_pkg::spq_result_t result,
  output int                   errors,
  output int                   pending
);
  import spq_pkg::*;

  // shadow rings
  logic [31:0]      ring_task [LEVELS][QUEUE_DEPTH];
  logic [31:0]      ring_arg  [LEVELS][QUEUE_DEPTH];
  logic [PTR_W-1:0] head      [LEVELS];
  logic [PTR_W-1:0] tail      [LEVELS];
  int unsigned      fill      [LEVELS];

  spq_result_t      expected_results[$];

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  // applies one command word to the shadow rings, returns the result word due
  function automatic spq_result_t schedule_word(input spq_cmd_t w);
    spq_result_t r;
    int          lvl;
    r = '0;
    if (w.mode == MODE_PUSH) begin
      if (w.priority_req == 4'd0 || int'(w.priority_req) > LEVELS) begin
        r.push_dropped = 1'b1;
      end else begin
        lvl = int'(w.priority_req) - 1;
        if (fill[lvl] >= QUEUE_DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          ring_task[lvl][tail[lvl]] = w.task_handle;
          ring_arg[lvl][tail[lvl]]  = w.argument_handle;
          tail[lvl] = advance(tail[lvl]);
          fill[lvl]++;
        end
      end
    end else begin
      // lowest-numbered non-empty level wins
      for (lvl = 0; lvl < LEVELS; lvl++) begin
        if (fill[lvl] != 0) begin
          r.entry_valid  = 1'b1;
          r.task_out     = ring_task[lvl][head[lvl]];
          r.argument_out = ring_arg[lvl][head[lvl]];
          head[lvl] = advance(head[lvl]);
          fill[lvl]--;
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    spq_result_t want;
    if (rst) begin
      foreach (fill[i]) begin
        head[i] = '0;
        tail[i] = '0;
        fill[i] = 0;
      end
      expected_results.delete();
      errors = 0;
    end else begin
      // result of an earlier word is checked before the new word is predicted
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got valid=%0b task=%h arg=%h drop=%0b",
                   $time, result.entry_valid, result.task_out, result.argument_out,
                   result.push_dropped);
        end else begin
          want = expected_results.pop_front();
          if (result.entry_valid !== want.entry_valid || result.task_out !== want.task_out ||
              result.argument_out !== want.argument_out ||
              result.push_dropped !== want.push_dropped) begin
            errors++;
            $display("%0t: result mismatch: expected valid=%0b task=%h arg=%h drop=%0b",
                     $time, want.entry_valid, want.task_out, want.argument_out,
                     want.push_dropped);
            $display("%0t:                  actual valid=%0b task=%h arg=%h drop=%0b",
                     $time, result.entry_valid, result.task_out, result.argument_out,
                     result.push_dropped);
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(schedule_word(cmd));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import spq_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  spq_cmd_t    cmd;
  logic        done;
  spq_result_t result;
  int          errors;
  int          pending;

  strict_priority_task_queues_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  spq_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Holds one word on the command port until it is taken. Called at a rising
  // edge; returns at the edge that accepted the word.
  task automatic issue(input spq_cmd_t w);
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
  endtask

  // drives start low and waits for a clock edge
  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic spq_cmd_t make_word(input logic m, input logic [31:0] tsk,
                                         input logic [31:0] argw, input logic [3:0] p);
    spq_cmd_t w;
    w.mode            = m;
    w.task_handle     = tsk;
    w.argument_handle = argw;
    w.priority_req    = p;
    return w;
  endfunction

  // Random word. Most pushes go to one hot level so that rings fill up and
  // drops happen; a few pushes carry a priority outside 1..LEVELS.
  function automatic spq_cmd_t random_word(input int push_pct, input logic [3:0] hot);
    spq_cmd_t w;
    int       roll;
    w.task_handle     = $urandom;
    w.argument_handle = $urandom;
    w.priority_req    = 4'($urandom_range(1, LEVELS));
    roll              = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < push_pct) begin
      w.mode = MODE_PUSH;
      if (roll < 70) begin
        w.priority_req = hot;
      end else if (roll >= 95) begin
        w.priority_req = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(LEVELS + 1, 15));
      end
    end else begin
      w.mode = MODE_POP;
    end
    return w;
  endfunction

  initial begin
    // idle percentage per phase: none, sender idling, receiver stalling (the
    // result port has no backpressure, so nothing to do there), both
    int         idle_pct [4];
    int         push_mix [3];
    int         push_pct;
    logic [3:0] hot;

    idle_pct = '{0, 61, 0, 32};
    push_mix = '{85, 50, 20};

    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed words ---
    issue(make_word(MODE_POP, 32'h0, 32'h0, 4'd1));                    // pop with all empty
    issue(make_word(MODE_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0));   // priority zero
    issue(make_word(MODE_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));  // priority above range
    issue(make_word(MODE_PUSH, 32'h0, 32'h0, 4'(LEVELS)));             // lowest level
    issue(make_word(MODE_PUSH, 32'hFFFF_FFFF, 32'h0, 4'd1));           // highest level
    issue(make_word(MODE_PUSH, 32'h0, 32'hFFFF_FFFF, 4'd5));
    // pops come back in level order, then empty again
    repeat (4) issue(make_word(MODE_POP, $urandom, $urandom, 4'($urandom)));
    // fill level 1 to the brim, then one push too many
    repeat (QUEUE_DEPTH + 1) issue(make_word(MODE_PUSH, $urandom, $urandom, 4'd1));

    // --- random words: four idle phases, each in segments of varying push mix ---
    for (int ph = 0; ph < 4; ph++) begin
      for (int seg = 0; seg < 8; seg++) begin
        push_pct = push_mix[$urandom_range(0, 2)];
        hot      = 4'($urandom_range(1, LEVELS));
        for (int n = 0; n < 20; n++) begin
          while ($urandom_range(0, 99) < idle_pct[ph]) idle_cycle();
          issue(random_word(push_pct, hot));
        end
      end
    end
    start <= 1'b0;

    // drain: wait until no result is pending, then catch stray results
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
